// ===== hdl/tlp_pkg.sv =====
// tlp_pkg: shared types, codes and character helpers for the telemetry line parser.
// Used by tlp_parser and telemetry_line_parser; depends on nothing.
`timescale 1ns / 1ps

package tlp_pkg;

    localparam int NUM_VALUES = 12;
    localparam int IDX_W      = 4;

    localparam logic       ACTION_BYTE = 1'b0;
    localparam logic       ACTION_READ = 1'b1;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_B      = 8'h42;
    localparam logic [7:0] CHAR_C      = 8'h43;
    localparam logic [7:0] CHAR_R      = 8'h52;

    typedef enum logic [1:0] {
        KIND_UPDATE  = 2'd0,
        KIND_UNKNOWN = 2'd1,
        KIND_READ    = 2'd2
    } kind_t;

    // line-end event from the parser toward the value store
    typedef struct packed {
        logic             fire;
        kind_t            kind;
        logic [IDX_W-1:0] index;
    } line_evt_t;

    typedef struct packed {
        logic             known;
        logic [IDX_W-1:0] index;
    } tag_hit_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c inside {[8'h30:8'h39]});
    endfunction

    // order B0 B1 B2 C0..C4 R0..R3
    function automatic tag_hit_t tag_lookup(input logic [7:0] letter, input logic [7:0] digit);
        tag_hit_t   hit;
        logic [7:0] d;
        hit.known = 1'b0;
        hit.index = '0;
        d = digit - CHAR_ZERO;
        if (is_digit(digit)) begin
            if (letter == CHAR_B && d <= 8'd2) begin
                hit.known = 1'b1;
                hit.index = d[IDX_W-1:0];
            end else if (letter == CHAR_C && d <= 8'd4) begin
                hit.known = 1'b1;
                hit.index = d[IDX_W-1:0] + 4'd3;
            end else if (letter == CHAR_R && d <= 8'd3) begin
                hit.known = 1'b1;
                hit.index = d[IDX_W-1:0] + 4'd8;
            end
        end
        return hit;
    endfunction

endpackage

// ===== hdl/tlp_ram.sv =====
// tlp_ram: generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`timescale 1ns / 1ps

module tlp_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 12
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/tlp_parser.sv =====
// tlp_parser: per-line character state and decimal accumulation; flags a line-end event.
// Depends on tlp_pkg.
`timescale 1ns / 1ps

module tlp_parser #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   byte_en,
    input  logic [7:0]             rx_byte,
    output tlp_pkg::line_evt_t     evt,
    output logic [VALUE_WIDTH-1:0] evt_data
);

    localparam int WIDE_W = VALUE_WIDTH + 4;

    logic [2:0]             pos_reg, pos_next;
    logic [7:0]             letter_reg, letter_next;
    logic [7:0]             digit_reg, digit_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   bad_reg, bad_next;
    logic                   last_digit_reg, last_digit_next;

    logic                   is_term;
    logic                   formed;
    logic                   c_digit;
    tlp_pkg::tag_hit_t      hit;
    logic [7:0]             d;
    logic [WIDE_W-1:0]      wide;

    assign is_term = (rx_byte == tlp_pkg::CHAR_CR) || (rx_byte == tlp_pkg::CHAR_LF);
    assign c_digit = tlp_pkg::is_digit(rx_byte);
    assign d       = rx_byte - tlp_pkg::CHAR_ZERO;
    assign formed  = (pos_reg >= 3'd4) && tlp_pkg::is_alpha(letter_reg)
                     && !tlp_pkg::is_alpha(digit_reg) && last_digit_reg;
    assign hit     = tlp_pkg::tag_lookup(letter_reg, digit_reg);

    // acc * 10 + digit, wide enough to see overflow
    assign wide = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                  + {{(WIDE_W-4){1'b0}}, d[3:0]};

    always_comb begin
        evt.fire  = byte_en && is_term && formed && (!hit.known || !bad_reg);
        evt.kind  = hit.known ? tlp_pkg::KIND_UPDATE : tlp_pkg::KIND_UNKNOWN;
        evt.index = hit.known ? hit.index : '0;
        evt_data  = hit.known ? acc_reg : '0;
    end

    always_comb begin
        pos_next        = pos_reg;
        letter_next     = letter_reg;
        digit_next      = digit_reg;
        acc_next        = acc_reg;
        bad_next        = bad_reg;
        last_digit_next = last_digit_reg;
        if (byte_en) begin
            if (is_term) begin
                pos_next        = '0;
                letter_next     = '0;
                digit_next      = '0;
                acc_next        = '0;
                bad_next        = 1'b0;
                last_digit_next = 1'b0;
            end else begin
                if (pos_reg == 3'd0) begin
                    letter_next = rx_byte;
                end else if (pos_reg == 3'd1) begin
                    digit_next = rx_byte;
                end else if (pos_reg >= 3'd3) begin
                    if (!c_digit) begin
                        bad_next = 1'b1;
                    end else if (!bad_reg) begin
                        if (|wide[WIDE_W-1:VALUE_WIDTH]) begin
                            bad_next = 1'b1;
                        end else begin
                            acc_next = wide[VALUE_WIDTH-1:0];
                        end
                    end
                end
                last_digit_next = c_digit;
                if (pos_reg < 3'd4) begin
                    pos_next = pos_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            letter_reg     <= '0;
            digit_reg      <= '0;
            acc_reg        <= '0;
            bad_reg        <= 1'b0;
            last_digit_reg <= 1'b0;
        end else begin
            pos_reg        <= pos_next;
            letter_reg     <= letter_next;
            digit_reg      <= digit_next;
            acc_reg        <= acc_next;
            bad_reg        <= bad_next;
            last_digit_reg <= last_digit_next;
        end
    end

endmodule

// ===== hdl/telemetry_line_parser.sv =====
// telemetry_line_parser: top level; value store RAM, result stage and output register.
// Depends on tlp_pkg, tlp_parser and tlp_ram.
//
// Usage: each request on the s_ channel is either a received byte (s_action = 0)
// or a read of a stored value (s_action = 1). Bytes are cut into lines at CR or LF.
// A well-formed line with a known tag B0-B2, C0-C4, R0-R3 and an all-digit
// payload that fits in VALUE_WIDTH bits writes its value into the store and
// returns an update result; one with any other tag returns an unknown-tag result;
// all other lines give nothing. A read always returns one result with the
// stored value (zero past index 11). A result passes the result stage (which
// takes the registered RAM read) and then the output register to reach m_.
// Throughput: one request per cycle while m_ready is high; the rate is set by the
// single-port read of the value RAM, one access per request.
// Stall: with m_ready low the output register and the result stage each hold one
// result; s_ready drops only once both are full.
// Reset: aresetn (synchronous) clears line state and the per-entry valid bits,
// so all stored values read as zero at once; no clearing pass is needed.
`timescale 1ns / 1ps

module telemetry_line_parser #(
    parameter int VALUE_WIDTH = 31
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_action,
    input  logic [7:0]                  s_rx_byte,
    input  logic [tlp_pkg::IDX_W-1:0]   s_read_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_result_kind,
    output logic [tlp_pkg::IDX_W-1:0]   m_value_index,
    output logic [VALUE_WIDTH-1:0]      m_value_data
);

    logic                        s_acc;
    logic                        byte_en;
    logic                        read_go;
    logic                        in_range;
    tlp_pkg::line_evt_t          evt;
    logic [VALUE_WIDTH-1:0]      evt_data;
    logic                        wr_en;
    logic [VALUE_WIDTH-1:0]      rdata;
    logic                        load_s1;
    logic                        advance;

    logic [tlp_pkg::NUM_VALUES-1:0] written_reg;

    logic                        s1_valid_reg;
    tlp_pkg::kind_t              s1_kind_reg;
    logic [tlp_pkg::IDX_W-1:0]   s1_index_reg;
    logic [VALUE_WIDTH-1:0]      s1_data_reg;
    logic                        s1_use_ram_reg;
    logic                        s1_ok_reg;

    logic                        m_valid_reg;
    tlp_pkg::kind_t              m_kind_reg;
    logic [tlp_pkg::IDX_W-1:0]   m_index_reg;
    logic [VALUE_WIDTH-1:0]      m_data_reg;

    assign s_acc    = s_valid && s_ready;
    assign byte_en  = s_acc && (s_action == tlp_pkg::ACTION_BYTE);
    assign read_go  = s_acc && (s_action == tlp_pkg::ACTION_READ);
    assign in_range = s_read_index < tlp_pkg::IDX_W'(tlp_pkg::NUM_VALUES);
    assign wr_en    = evt.fire && (evt.kind == tlp_pkg::KIND_UPDATE);
    assign load_s1  = evt.fire || read_go;
    assign advance  = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || advance;

    tlp_parser #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .byte_en  (byte_en),
        .rx_byte  (s_rx_byte),
        .evt      (evt),
        .evt_data (evt_data)
    );

    // writes and reads come from different requests, so never collide in a cycle
    tlp_ram #(
        .WIDTH(VALUE_WIDTH),
        .DEPTH(tlp_pkg::NUM_VALUES)
    ) u_store (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (evt.index),
        .wdata (evt_data),
        .re    (read_go && in_range),
        .raddr (s_read_index),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg  <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                written_reg[evt.index] <= 1'b1;
            end
            if (load_s1) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_s1) begin
            if (read_go) begin
                s1_kind_reg    <= tlp_pkg::KIND_READ;
                s1_index_reg   <= s_read_index;
                s1_data_reg    <= '0;
                s1_use_ram_reg <= 1'b1;
                s1_ok_reg      <= in_range && written_reg[s_read_index];
            end else begin
                s1_kind_reg    <= evt.kind;
                s1_index_reg   <= evt.index;
                s1_data_reg    <= evt_data;
                s1_use_ram_reg <= 1'b0;
                s1_ok_reg      <= 1'b0;
            end
        end
        if (advance) begin
            m_kind_reg  <= s1_kind_reg;
            m_index_reg <= s1_index_reg;
            if (s1_use_ram_reg) begin
                m_data_reg <= s1_ok_reg ? rdata : '0;
            end else begin
                m_data_reg <= s1_data_reg;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_value_index = m_index_reg;
    assign m_value_data  = m_data_reg;

endmodule
